// ===== src/mdd_pkg.sv =====
// Shared types and constants for the Morse dibit decoder.
// Used by every module of the block but mdd_fifo; depends on nothing.
`default_nettype none

package mdd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_SYMBOLS   = 8;

  localparam int IDX_IN_W = 6;
  localparam int CODE_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int BYTE_W   = 8;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [1:0] DIBIT_END   = 2'b00;
  localparam logic [1:0] DIBIT_DASH  = 2'b01;
  localparam logic [1:0] DIBIT_DOT   = 2'b10;
  localparam logic [1:0] DIBIT_SPACE = 2'b11;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

  typedef struct packed {
    logic                is_load;
    logic [IDX_IN_W-1:0] slot;
    logic [CODE_W-1:0]   code;
    logic [CHAR_W-1:0]   chr;
    logic                ent_valid;
    logic [BYTE_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              space;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] chr;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/mdd_fifo.sv =====
// Small synchronous first-in first-out queue with full and empty flags.
// Generic; used for the command queue and the result queue.
`default_nettype none

module mdd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/mdd_front.sv =====
// Front end of the Morse dibit decoder: accepts input transactions, classifies
// them and queues commands for the back end. Depends on mdd_pkg and mdd_fifo.
`default_nettype none

module mdd_front #(
  parameter int TableEntries = mdd_pkg::TABLE_ENTRIES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic                          mode_i,
  input  wire logic [mdd_pkg::IDX_IN_W-1:0]  entry_index_i,
  input  wire logic [mdd_pkg::CODE_W-1:0]    entry_code_i,
  input  wire logic [mdd_pkg::CHAR_W-1:0]    entry_char_i,
  input  wire logic                          entry_valid_i,
  input  wire logic [mdd_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                          cmd_pop_i,
  output mdd_pkg::cmd_t                      cmd_o,
  output logic                               cmd_empty_o
);

  mdd_pkg::cmd_t cmd_in;
  logic          keep;

  // A load aimed beyond the table is accepted but has no effect, so it is
  // dropped here and never reaches the back end.
  assign keep = (mode_i == mdd_pkg::MODE_DECODE) ||
                (32'(entry_index_i) < 32'(TableEntries));

  always_comb begin
    cmd_in.is_load   = (mode_i == mdd_pkg::MODE_LOAD);
    cmd_in.slot      = entry_index_i;
    cmd_in.code      = entry_code_i;
    cmd_in.chr       = entry_char_i;
    cmd_in.ent_valid = entry_valid_i;
    cmd_in.data      = data_byte_i;
  end

  mdd_fifo #(
    .Width($bits(mdd_pkg::cmd_t)),
    .Depth(mdd_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && keep),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .empty_o(cmd_empty_o)
  );

endmodule

`default_nettype wire

// ===== src/mdd_back.sv =====
// Back end of the Morse dibit decoder: owns the letter table, walks the dibits
// of each data byte and produces result transactions. Depends on mdd_pkg.
`default_nettype none

module mdd_back #(
  parameter int TableEntries = mdd_pkg::TABLE_ENTRIES,
  parameter int MaxSymbols   = mdd_pkg::MAX_SYMBOLS
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_empty_i,
  input  wire mdd_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output mdd_pkg::res_t       res_o
);

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(MaxSymbols + 1);
  localparam int CW   = mdd_pkg::CODE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIBIT = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [mdd_pkg::BYTE_W-1:0]  byte_q, byte_d;
  logic [1:0]                  pos_q, pos_d;
  logic [CW-1:0]               accum_q, accum_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        ovf_q, ovf_d;
  logic [IdxW-1:0]             scan_q, scan_d;
  logic [TableEntries-1:0]     valid_q, valid_d;
  mdd_pkg::res_t               hold_q, hold_d;
  logic                        hold_vld_q, hold_vld_d;

  mdd_pkg::entry_t             mem_q [TableEntries];
  mdd_pkg::entry_t             rdata_q;
  mdd_pkg::entry_t             wdata;
  logic                        mem_we, mem_re;
  logic [IdxW-1:0]             waddr;

  logic [1:0]                  dibit;
  logic                        can_emit;
  logic                        emit_req;
  logic [mdd_pkg::CHAR_W-1:0]  emit_chr;
  logic                        emit_sp;
  logic                        hit;

  assign dibit    = byte_q[mdd_pkg::BYTE_W-1 -: 2];
  assign can_emit = !hold_vld_q || !res_full_i;
  assign waddr    = IdxW'(cmd_i.slot);
  assign wdata    = '{code: cmd_i.code, chr: cmd_i.chr};
  assign hit      = valid_q[scan_q] && (rdata_q.code == accum_q);

  always_comb begin
    state_d    = state_q;
    byte_d     = byte_q;
    pos_d      = pos_q;
    accum_d    = accum_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    scan_d     = scan_q;
    valid_d    = valid_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    emit_req   = 1'b0;
    emit_chr   = mdd_pkg::SPACE_CHAR;
    emit_sp    = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{chr: hold_q.chr, space: hold_q.space, last: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_load) begin
            mem_we         = 1'b1;
            valid_d[waddr] = cmd_i.ent_valid;
          end else begin
            byte_d  = cmd_i.data;
            pos_d   = 2'd0;
            state_d = S_DIBIT;
          end
        end
      end

      S_DIBIT: begin
        unique case (dibit)
          mdd_pkg::DIBIT_DOT, mdd_pkg::DIBIT_DASH: begin
            if (cnt_q == CntW'(MaxSymbols)) begin
              ovf_d = 1'b1;
            end else begin
              accum_d = {accum_q[CW-3:0], dibit};
              cnt_d   = cnt_q + CntW'(1);
            end
            byte_d  = byte_q << 2;
            pos_d   = pos_q + 2'd1;
            state_d = (pos_q == 2'd3) ? S_FLUSH : S_DIBIT;
          end
          mdd_pkg::DIBIT_SPACE: begin
            emit_req = 1'b1;
            emit_sp  = 1'b1;
            if (can_emit) begin
              byte_d  = byte_q << 2;
              pos_d   = pos_q + 2'd1;
              state_d = (pos_q == 2'd3) ? S_FLUSH : S_DIBIT;
            end
          end
          mdd_pkg::DIBIT_END: begin
            if (!ovf_q && (accum_q != '0)) begin
              scan_d  = '0;
              state_d = S_READ;
            end else begin
              accum_d = '0;
              cnt_d   = '0;
              ovf_d   = 1'b0;
              byte_d  = byte_q << 2;
              pos_d   = pos_q + 2'd1;
              state_d = (pos_q == 2'd3) ? S_FLUSH : S_DIBIT;
            end
          end
        endcase
      end

      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_CMP;
      end

      S_CMP: begin
        if (hit) begin
          emit_req = 1'b1;
          emit_chr = rdata_q.chr;
        end
        if ((hit && can_emit) || (!hit && (scan_q == IdxW'(TableEntries - 1)))) begin
          accum_d = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          byte_d  = byte_q << 2;
          pos_d   = pos_q + 2'd1;
          state_d = (pos_q == 2'd3) ? S_FLUSH : S_DIBIT;
        end else if (!hit) begin
          scan_d  = scan_q + IdxW'(1);
          state_d = S_READ;
        end
      end

      S_FLUSH: begin
        if (!hold_vld_q) begin
          state_d = S_IDLE;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A new result first sends the one held before it, which then cannot be
    // the last of its byte.
    if (emit_req && can_emit) begin
      if (hold_vld_q) begin
        res_push_o = 1'b1;
      end
      hold_d     = '{chr: emit_chr, space: emit_sp, last: 1'b0};
      hold_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      accum_q    <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      scan_q     <= '0;
      valid_q    <= '0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      accum_q    <= accum_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      scan_q     <= scan_d;
      valid_q    <= valid_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hold_q <= hold_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[scan_q];
    end
  end

endmodule

`default_nettype wire

// ===== src/morse_dibit_decoder.sv =====
// Morse dibit decoder top level: front end, back end and result queue.
// Depends on mdd_pkg, mdd_fifo, mdd_front and mdd_back.
//
// The block takes transactions on a queue-style input (push/full) and hands
// out decoded characters on a queue-style output (empty/pop). A transaction
// with mode 0 writes one slot of the letter table; mode 1 decodes a data byte
// holding four 2-bit symbols, most significant pair first: 10 is a dot, 01 a
// dash, 00 ends a letter and 11 is a word space. A byte yields zero to four
// result transactions, the final one flagged by last. Each result enters the
// result queue as soon as the next result of its byte is found, and the final
// one once the whole byte has been walked. A table load is written from the
// idle state of the back end. A data byte is taken from the command queue in
// the idle state, walked symbol by symbol in the dibit state and its final
// result is released in the flush state, and every end of letter with a
// nonempty code that stayed within the symbol limit adds a search of the
// single-port table memory, a read state and a compare state per slot,
// stopping at the first match or after the last slot. A full result queue
// stalls the back end until a result is popped. A two-entry command queue lets
// the front accept transactions while the back end is busy, and a four-entry
// result queue decouples the output.
// Slot valid bits are flip-flops cleared by reset, so no clearing pass runs.
`default_nettype none

module morse_dibit_decoder #(
  parameter int TableEntries = mdd_pkg::TABLE_ENTRIES,
  parameter int MaxSymbols   = mdd_pkg::MAX_SYMBOLS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          mode_i,
  input  wire logic [mdd_pkg::IDX_IN_W-1:0]  entry_index_i,
  input  wire logic [mdd_pkg::CODE_W-1:0]    entry_code_i,
  input  wire logic [mdd_pkg::CHAR_W-1:0]    entry_char_i,
  input  wire logic                          entry_valid_i,
  input  wire logic [mdd_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic      [mdd_pkg::CHAR_W-1:0]    out_char_o,
  output logic                               is_space_o,
  output logic                               last_o
);

  mdd_pkg::cmd_t cmd;
  logic          cmd_empty;
  logic          cmd_pop;
  mdd_pkg::res_t res;
  logic          res_push;
  logic          res_full;
  mdd_pkg::res_t res_out;

  // Front end: accepts input transactions while its queue has room and queues
  // the ones that have any effect.
  mdd_front #(
    .TableEntries(TableEntries)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .mode_i       (mode_i),
    .entry_index_i(entry_index_i),
    .entry_code_i (entry_code_i),
    .entry_char_i (entry_char_i),
    .entry_valid_i(entry_valid_i),
    .data_byte_i  (data_byte_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd),
    .cmd_empty_o  (cmd_empty)
  );

  // Back end: table writes, symbol walking and table search.
  mdd_back #(
    .TableEntries(TableEntries),
    .MaxSymbols  (MaxSymbols)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result queue in front of the output ports.
  mdd_fifo #(
    .Width($bits(mdd_pkg::res_t)),
    .Depth(mdd_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign out_char_o = res_out.chr;
  assign is_space_o = res_out.space;
  assign last_o     = res_out.last;

  // The back end only writes results when the queue has room, so none is lost.
  a_no_res_overrun: assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full
  ) else $error("result written into a full queue");

  // The back end only takes commands that are really waiting.
  a_no_cmd_underrun: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty
  ) else $error("command taken from an empty queue");

endmodule

`default_nettype wire

// ===== tb/mdd_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Morse dibit decoder: it mirrors the letter table and the
// letter being built, predicts every result transaction and checks it.
// Depends on mdd_pkg.
module mdd_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic                         full_i,
  input  wire logic                         mode_i,
  input  wire logic [mdd_pkg::IDX_IN_W-1:0] entry_index_i,
  input  wire logic [mdd_pkg::CODE_W-1:0]   entry_code_i,
  input  wire logic [mdd_pkg::CHAR_W-1:0]   entry_char_i,
  input  wire logic                         entry_valid_i,
  input  wire logic [mdd_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic                         empty_i,
  input  wire logic                         pop_i,
  input  wire logic [mdd_pkg::CHAR_W-1:0]   out_char_i,
  input  wire logic                         is_space_i,
  input  wire logic                         last_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                loads_o,
  output int                                bytes_o,
  output int                                chars_o,
  output int                                spaces_o,
  output int                                dropped_o
);
  import mdd_pkg::*;

  logic [CODE_W-1:0] tbl_code [TABLE_ENTRIES];
  logic [CHAR_W-1:0] tbl_char [TABLE_ENTRIES];
  logic              tbl_on   [TABLE_ENTRIES];

  logic [CODE_W-1:0] letter_code;
  int unsigned       letter_len;
  logic              letter_ovf;

  res_t decoded_q [$];

  int n_errors = 0;
  int n_loads = 0;
  int n_bytes = 0;
  int n_chars = 0;
  int n_spaces = 0;
  int n_dropped = 0;

  // Walks the four symbols of a byte, most significant pair first, and queues
  // the characters they produce; the final one of the byte carries last.
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    res_t       found [4];
    int         n;
    int         p;
    int         s;
    int         hit;
    logic [1:0] d;
    n = 0;
    for (p = 3; p >= 0; p--) begin
      d = b[2*p +: 2];
      case (d)
        DIBIT_DOT, DIBIT_DASH: begin
          if (letter_len >= MAX_SYMBOLS) begin
            letter_ovf = 1'b1;
          end else begin
            letter_code = {letter_code[CODE_W-3:0], d};
            letter_len++;
          end
        end
        DIBIT_SPACE: begin
          found[n] = {SPACE_CHAR, 1'b1, 1'b0};
          n++;
          n_spaces++;
        end
        default: begin
          if (letter_ovf) begin
            n_dropped++;
          end else if (letter_code != '0) begin
            hit = -1;
            for (s = 0; s < TABLE_ENTRIES && hit < 0; s++)
              if (tbl_on[s] && tbl_code[s] == letter_code) hit = s;
            if (hit >= 0) begin
              found[n] = {tbl_char[hit], 1'b0, 1'b0};
              n++;
              n_chars++;
            end
          end
          letter_code = '0;
          letter_len  = 0;
          letter_ovf  = 1'b0;
        end
      endcase
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (p = 0; p < n; p++) decoded_q.insert(decoded_q.size(), found[p]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    int   s;
    if (!rst_ni) begin
      letter_code = '0;
      letter_len  = 0;
      letter_ovf  = 1'b0;
      for (s = 0; s < TABLE_ENTRIES; s++) tbl_on[s] = 1'b0;
      decoded_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (decoded_q.size() == 0) begin
          $error("out_char: expected no transaction, actual %0d", out_char_i);
          n_errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_char_i !== want.chr) begin
            $error("out_char: expected %0d, actual %0d", want.chr, out_char_i);
            n_errors++;
          end
          if (is_space_i !== want.space) begin
            $error("is_space: expected %0d, actual %0d", want.space, is_space_i);
            n_errors++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            n_errors++;
          end
        end
      end
      if (push_i && !full_i) begin
        if (mode_i == MODE_LOAD) begin
          n_loads++;
          if (entry_index_i < TABLE_ENTRIES) begin
            tbl_code[entry_index_i] = entry_code_i;
            tbl_char[entry_index_i] = entry_char_i;
            tbl_on[entry_index_i]   = entry_valid_i;
          end
        end else begin
          n_bytes++;
          decode_byte(data_byte_i);
        end
      end
    end
    errors_o  <= n_errors;
    pending_o <= decoded_q.size();
    loads_o   <= n_loads;
    bytes_o   <= n_bytes;
    chars_o   <= n_chars;
    spaces_o  <= n_spaces;
    dropped_o <= n_dropped;
  end

endmodule

// ===== tb/tb_morse_dibit_decoder.sv =====
`timescale 1ns / 1ps
// Testbench top for the Morse dibit decoder: clock, reset, input stimulus,
// random popping of results and the final verdict.
// Depends on mdd_pkg, mdd_checker and the decoder RTL.
module tb_morse_dibit_decoder;
  import mdd_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  // The tail of the run goes without any idling on either side.
  localparam int CALM_ITEMS   = 60;
  // One long hold-off of the receiver, so that both queues fill up.
  localparam int HOLD_CYCLES  = 300;
  // A byte ends at most two nonempty unmatched letters, which can keep the back
  // end busy for two full table searches without producing anything.
  localparam int DRAIN_CYCLES = 4 * (2 * TABLE_ENTRIES + 8) + 64;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                push = 1'b0;
  logic                full;
  logic                in_mode = MODE_DECODE;
  logic [IDX_IN_W-1:0] in_index = '0;
  logic [CODE_W-1:0]   in_code = '0;
  logic [CHAR_W-1:0]   in_char = '0;
  logic                in_valid = 1'b0;
  logic [BYTE_W-1:0]   in_byte = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [CHAR_W-1:0]   res_char;
  logic                res_space;
  logic                res_last;

  int errors, pending, n_loads, n_bytes, n_chars, n_spaces, n_dropped;

  // Our own view of what each slot holds, so that the symbol stream can be
  // made of letters that the table knows. slot_len is 0 for codes that no
  // run of dots and dashes can produce.
  logic [CODE_W-1:0] slot_code [TABLE_ENTRIES];
  int                slot_len  [TABLE_ENTRIES];

  // Symbols waiting to be packed into data bytes, four to a byte.
  logic [1:0] sym_q [$];

  bit hold_req = 1'b0;
  bit calm = 1'b0;

  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  morse_dibit_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (in_mode),
    .entry_index_i (in_index),
    .entry_code_i  (in_code),
    .entry_char_i  (in_char),
    .entry_valid_i (in_valid),
    .data_byte_i   (in_byte),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (res_char),
    .is_space_o    (res_space),
    .last_o        (res_last)
  );

  mdd_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .mode_i        (in_mode),
    .entry_index_i (in_index),
    .entry_code_i  (in_code),
    .entry_char_i  (in_char),
    .entry_valid_i (in_valid),
    .data_byte_i   (in_byte),
    .empty_i       (empty),
    .pop_i         (pop),
    .out_char_i    (res_char),
    .is_space_i    (res_space),
    .last_i        (res_last),
    .errors_o      (errors),
    .pending_o     (pending),
    .loads_o       (n_loads),
    .bytes_o       (n_bytes),
    .chars_o       (n_chars),
    .spaces_o      (n_spaces),
    .dropped_o     (n_dropped)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Builds the letter code of len symbols; bit i of pattern picks a dot (1) or
  // a dash (0), the highest bit going first.
  function automatic logic [CODE_W-1:0] symbols_to_code(input int len,
                                                        input logic [31:0] pattern);
    logic [CODE_W-1:0] code;
    int                i;
    code = '0;
    for (i = len - 1; i >= 0; i--)
      code = {code[CODE_W-3:0], pattern[i] ? DIBIT_DOT : DIBIT_DASH};
    return code;
  endfunction

  // Offers one transaction and returns at the edge that accepts it. A random
  // idle burst may come first. Since push stays high from one transaction to
  // the next, back-to-back transactions go in on consecutive edges unless full holds them.
  task automatic send_item(input logic m, input logic [IDX_IN_W-1:0] idx,
                           input logic [CODE_W-1:0] code, input logic [CHAR_W-1:0] chr,
                           input logic vld, input logic [BYTE_W-1:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push     <= 1'b1;
    in_mode  <= m;
    in_index <= idx;
    in_code  <= code;
    in_char  <= chr;
    in_valid <= vld;
    in_byte  <= b;
    // The values read right after the edge are the ones the edge sampled.
    do @(posedge clk_i); while (full);
  endtask

  // Table load; the unused data byte carries random bits.
  task automatic load_slot(input int idx, input logic [CODE_W-1:0] code, input int len,
                           input logic [CHAR_W-1:0] chr, input logic vld);
    slot_code[idx] = code;
    slot_len[idx]  = len;
    send_item(MODE_LOAD, IDX_IN_W'(idx), code, chr, vld, BYTE_W'($urandom));
  endtask

  // Data byte; the unused table fields carry random bits.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_item(MODE_DECODE, IDX_IN_W'($urandom), CODE_W'($urandom), CHAR_W'($urandom),
              1'($urandom), b);
  endtask

  // Appends one letter and its end mark to the symbol stream. Most letters
  // come from the table, the rest are random codes, letters that run past
  // the symbol limit and empty letters. A word space follows now and then.
  task automatic add_letter();
    int                kind;
    int                len;
    int                s;
    int                i;
    logic [CODE_W-1:0] code;
    kind = $urandom_range(0, 99);
    len  = 0;
    code = '0;
    if (kind < 70) begin
      s    = $urandom_range(0, TABLE_ENTRIES - 1);
      len  = slot_len[s];
      code = slot_code[s];
    end else if (kind < 80) begin
      len  = $urandom_range(1, 6);
      code = symbols_to_code(len, $urandom);
    end else if (kind < 88) begin
      // Too long to fit a code word, so the symbols go straight in.
      for (i = $urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 4); i > 0; i--)
        sym_q.insert(sym_q.size(), $urandom_range(0, 1) ? DIBIT_DOT : DIBIT_DASH);
    end
    for (i = len - 1; i >= 0; i--) sym_q.insert(sym_q.size(), code[2*i +: 2]);
    sym_q.insert(sym_q.size(), DIBIT_END);
    if ($urandom_range(0, 4) == 0) sym_q.insert(sym_q.size(), DIBIT_SPACE);
  endtask

  // Packs the next four symbols of the stream into a byte and sends it, so
  // letters freely straddle byte boundaries.
  task automatic send_stream_byte();
    logic [BYTE_W-1:0] b;
    int                i;
    b = '0;
    while (sym_q.size() < 4) add_letter();
    for (i = 0; i < 4; i++) b = {b[BYTE_W-3:0], sym_q.pop_front()};
    send_byte(b);
  endtask

  // Receiver: pops in random bursts, stalls in random bursts, and once holds
  // off for a long stretch while the sender keeps pushing.
  initial begin : receiver
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int                i;
    int                s;
    int                len;
    int                r;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] chr;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every slot is written before the first letter ends, since a search that
    // finds no match reads all of the table memory. The first 30 slots take
    // all codes of one to four symbols, a few of them cleared; the rest get
    // repeats of short codes (lower slots must win), longer codes and codes
    // that hold impossible symbol pairs.
    s = 0;
    for (len = 1; len <= 4; len++) begin
      for (i = 0; i < (1 << len); i++) begin
        load_slot(s, symbols_to_code(len, i), len, CHAR_W'(8'h41 + s), (s % 7) != 3);
        s++;
      end
    end
    while (s < TABLE_ENTRIES) begin
      r = $urandom_range(0, 2);
      if (r == 2) begin
        len  = 0;
        code = CODE_W'($urandom);
      end else begin
        len  = (r == 0) ? $urandom_range(1, 4) : $urandom_range(5, MAX_SYMBOLS);
        code = symbols_to_code(len, $urandom);
      end
      chr = CHAR_W'($urandom);
      load_slot(s, code, len, chr, $urandom_range(0, 3) != 0);
      s++;
    end

    // Directed part. The widest codes: eight dots and eight dashes.
    load_slot(TABLE_ENTRIES - 1, symbols_to_code(MAX_SYMBOLS, '1), MAX_SYMBOLS, '1, 1'b1);
    load_slot(TABLE_ENTRIES - 2, symbols_to_code(MAX_SYMBOLS, '0), MAX_SYMBOLS, '0, 1'b1);
    // Four ends of empty letters, then four word spaces.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Eight dots then an end; eight dashes then an end and three spaces.
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h3F);
    // A ninth dot marks the letter as too long, so its end drops it.
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h80);
    // A word space in the middle of a letter leaves the letter intact.
    send_byte(8'h9C);
    send_byte(8'hB0);
    // A cleared slot is skipped by the search, then written back.
    load_slot(0, slot_code[0], slot_len[0], 8'h41, 1'b0);
    send_byte(8'h40);
    load_slot(0, slot_code[0], slot_len[0], 8'h41, 1'b1);
    send_byte(8'h40);
    // A code that no letter can produce, with code and character at their extremes.
    load_slot(1, '1, 0, '0, 1'b0);
    send_byte(8'h4C);

    // Random part: mostly well-formed letter streams, some raw noise bytes
    // and table rewrites in between.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40) hold_req = 1'b1;
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        if ($urandom_range(0, 1) == 1) begin
          len  = $urandom_range(1, MAX_SYMBOLS);
          code = symbols_to_code(len, $urandom);
        end else begin
          len  = 0;
          code = CODE_W'($urandom);
        end
        chr = CHAR_W'($urandom);
        load_slot($urandom_range(0, TABLE_ENTRIES - 1), code, len, chr,
                  $urandom_range(0, 3) != 0);
      end else if (r < 22) begin
        send_byte(BYTE_W'($urandom));
      end else begin
        send_stream_byte();
      end
    end

    push <= 1'b0;
    // The checker's counts are registered, so step past the last acceptance
    // before looking at what is still outstanding.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: covered %0d table loads and %0d data bytes, %0d letters and %0d spaces",
             n_loads, n_bytes, n_chars, n_spaces);
    $display("tb: %0d letters ran past the symbol limit and were dropped", n_dropped);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
